### sv/mrpq_pkg.sv
package mrpq_pkg;

   // command codes of an input word
   localparam logic [1:0] CMD_ADD_REC   = 2'd0;
   localparam logic [1:0] CMD_REMOVE    = 2'd1;
   localparam logic [1:0] CMD_CLEAR     = 2'd2;
   localparam logic [1:0] CMD_ADD_MSG   = 2'd3;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic latch;
      logic rec_push;
      logic msg_push;
      logic clr_rec;
      logic read_msg_head;
      logic read_rec_head;
      logic pair_msg;
      logic pair_rec;
      logic res_none;
      logic res_drop;
      logic walk_init;
      logic walk_read;
      logic walk_write;
      logic walk_done;
      logic out_load;
   } dp_cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic       ch_ok;
      logic [1:0] cmd;
      logic       r_full;
      logic       r_nonempty;
      logic       m_nonempty;
      logic       m_full_eff;
      logic       walk_end;
      logic       out_free;
   } dp_status_type;

endpackage

### sv/message_recipient_pairing_queues_top.sv
// Rendezvous mailbox queues: each channel keeps a ring of waiting recipients
// and a ring of pending messages in on-chip memory, and every command word
// yields exactly one response word (a pair, a full-queue drop, or an empty
// word). One command is in flight at a time. Add recipient, clear and add
// message decide from the channel state, do one memory read when a pair
// forms, and then hand the word to the output register; remove-all walks the
// channel's recipient ring, reading each entry and writing back those kept.
// No clearing pass follows reset.
module message_recipient_pairing_queues_top #(
   parameter int CHANNELS       = 16,
   parameter int QUEUE_DEPTH    = 8,
   parameter int RECIPIENT_BITS = 8,
   parameter int VALUE_BITS     = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_channel,
   input  logic [7:0]  req_recipient,
   input  logic        req_has_value,
   input  logic [31:0] req_msg_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_paired,
   output logic [3:0]  rsp_out_channel,
   output logic [7:0]  rsp_out_recipient,
   output logic [31:0] rsp_out_value,
   output logic        rsp_value_is_name,
   output logic        rsp_status
);

   mrpq_pkg::dp_cmd_type    cmd;
   mrpq_pkg::dp_status_type st;

   // sequencer
   mrpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // queues and result path
   mrpq_dp #(
      .CHANNELS       (CHANNELS),
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .RECIPIENT_BITS (RECIPIENT_BITS),
      .VALUE_BITS     (VALUE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_cmd           (req_cmd),
      .req_channel       (req_channel),
      .req_recipient     (req_recipient),
      .req_has_value     (req_has_value),
      .req_msg_value     (req_msg_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_paired        (rsp_paired),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_out_recipient (rsp_out_recipient),
      .rsp_out_value     (rsp_out_value),
      .rsp_value_is_name (rsp_value_is_name),
      .rsp_status        (rsp_status),
      .cmd               (cmd),
      .st                (st)
   );

endmodule

### sv/mrpq_ctrl.sv
module mrpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mrpq_pkg::dp_status_type st,
   output mrpq_pkg::dp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECIDE  = 3'd1;
   localparam logic [2:0] S_PAIR    = 3'd2;
   localparam logic [2:0] S_WALK_RD = 3'd3;
   localparam logic [2:0] S_WALK_WR = 3'd4;
   localparam logic [2:0] S_FINISH  = 3'd5;

   logic [2:0] state_ff, state_in;

   // one word in flight at a time
   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_FINISH;
            if (!st.ch_ok) begin
               cmd.res_none = 1'b1;
            end else begin
               unique case (st.cmd)
                  mrpq_pkg::CMD_ADD_REC: begin
                     if (st.r_full) begin
                        cmd.res_drop = 1'b1;
                     end else if (st.m_nonempty) begin
                        cmd.read_msg_head = 1'b1;
                        state_in          = S_PAIR;
                     end else begin
                        cmd.rec_push = 1'b1;
                        cmd.res_none = 1'b1;
                     end
                  end
                  mrpq_pkg::CMD_REMOVE: begin
                     cmd.walk_init = 1'b1;
                     state_in      = S_WALK_RD;
                  end
                  mrpq_pkg::CMD_CLEAR: begin
                     cmd.clr_rec  = 1'b1;
                     cmd.res_none = 1'b1;
                  end
                  mrpq_pkg::CMD_ADD_MSG: begin
                     if (st.m_full_eff) begin
                        cmd.res_drop = 1'b1;
                     end else if (st.r_nonempty) begin
                        cmd.read_rec_head = 1'b1;
                        state_in          = S_PAIR;
                     end else begin
                        cmd.msg_push = 1'b1;
                        cmd.res_none = 1'b1;
                     end
                  end
                  default: begin
                     cmd.res_none = 1'b1;
                  end
               endcase
            end
         end
         S_PAIR: begin
            if (st.cmd == mrpq_pkg::CMD_ADD_REC) begin
               cmd.pair_msg = 1'b1;
            end else begin
               cmd.pair_rec = 1'b1;
            end
            state_in = S_FINISH;
         end
         S_WALK_RD: begin
            if (st.walk_end) begin
               cmd.walk_done = 1'b1;
               cmd.res_none  = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.walk_read = 1'b1;
               state_in      = S_WALK_WR;
            end
         end
         S_WALK_WR: begin
            cmd.walk_write = 1'b1;
            state_in       = S_WALK_RD;
         end
         S_FINISH: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/mrpq_dp.sv
module mrpq_dp #(
   parameter int CHANNELS       = 16,
   parameter int QUEUE_DEPTH    = 8,
   parameter int RECIPIENT_BITS = 8,
   parameter int VALUE_BITS     = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   input  logic [1:0]              req_cmd,
   input  logic [3:0]              req_channel,
   input  logic [7:0]              req_recipient,
   input  logic                    req_has_value,
   input  logic [31:0]             req_msg_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_paired,
   output logic [3:0]              rsp_out_channel,
   output logic [7:0]              rsp_out_recipient,
   output logic [31:0]             rsp_out_value,
   output logic                    rsp_value_is_name,
   output logic                    rsp_status,
   input  mrpq_pkg::dp_cmd_type    cmd,
   output mrpq_pkg::dp_status_type st
);

   localparam int CIW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW   = CNTW + 1;
   localparam int RSW  = (RECIPIENT_BITS < 8) ? RECIPIENT_BITS : 8;
   localparam int VSW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;

   // ring index: a + b modulo the queue depth, a below depth, b at most depth
   function automatic logic [QW-1:0] wrap_add(input logic [QW-1:0] a,
                                               input logic [CNTW-1:0] b);
      logic [SW-1:0] s;
      s = SW'(a) + SW'(b);
      if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
      return QW'(s);
   endfunction

   logic             allow_dup_ff;
   logic [1:0]       cmd_ff;
   logic [3:0]       ch_ff;
   logic [RSW-1:0]   rec_ff;
   logic             hv_ff;
   logic [VSW-1:0]   val_ff;

   logic [CNTW-1:0]  rcount_ff [CHANNELS];
   logic [QW-1:0]    rhead_ff  [CHANNELS];
   logic [CNTW-1:0]  mcount_ff [CHANNELS];
   logic [QW-1:0]    mhead_ff  [CHANNELS];

   logic [RSW-1:0]   rec_mem [CHANNELS][QUEUE_DEPTH];
   logic [VSW:0]     msg_mem [CHANNELS][QUEUE_DEPTH];
   logic [RSW-1:0]   rec_rdata_ff;
   logic [VSW:0]     msg_rdata_ff;

   logic [CNTW-1:0]  i_ff, w_ff;

   logic             res_paired_ff, res_name_ff, res_status_ff;
   logic [RSW-1:0]   res_rec_ff;
   logic [VSW-1:0]   res_val_ff;

   logic             out_valid_ff, out_paired_ff, out_name_ff, out_status_ff;
   logic [3:0]       out_ch_ff;
   logic [RSW-1:0]   out_rec_ff;
   logic [VSW-1:0]   out_val_ff;

   logic [CIW-1:0]   ch_idx;
   logic             ch_ok;
   logic [CNTW-1:0]  rcount_cur, mcount_cur, meff;
   logic [QW-1:0]    rhead_cur, mhead_cur;
   logic             walk_keep;

   // current channel view
   assign ch_idx     = CIW'(ch_ff);
   assign ch_ok      = (32'(ch_ff) < CHANNELS);
   assign rcount_cur = rcount_ff[ch_idx];
   assign mcount_cur = mcount_ff[ch_idx];
   assign rhead_cur  = rhead_ff[ch_idx];
   assign mhead_cur  = mhead_ff[ch_idx];
   assign meff       = allow_dup_ff ? mcount_cur : '0;
   assign walk_keep  = (rec_rdata_ff != rec_ff);

   // status to the sequencer
   always_comb begin
      st.ch_ok      = ch_ok;
      st.cmd        = cmd_ff;
      st.r_full     = (rcount_cur == CNTW'(QUEUE_DEPTH));
      st.r_nonempty = (rcount_cur != '0);
      st.m_nonempty = (mcount_cur != '0);
      st.m_full_eff = (meff == CNTW'(QUEUE_DEPTH));
      st.walk_end   = (i_ff == rcount_cur);
      st.out_free   = !out_valid_ff || !rsp_stall;
   end

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_dup_ff <= 1'b0;
      end else if (csr_write_enable) begin
         allow_dup_ff <= csr_write_data;
      end
   end

   // input word capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff <= req_cmd;
         ch_ff  <= req_channel;
         rec_ff <= req_recipient[RSW-1:0];
         hv_ff  <= req_has_value;
         val_ff <= req_msg_value[VSW-1:0];
      end
   end

   // per-channel counts and heads
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            rcount_ff[c] <= '0;
            rhead_ff[c]  <= '0;
            mcount_ff[c] <= '0;
            mhead_ff[c]  <= '0;
         end
      end else begin
         if (cmd.rec_push) rcount_ff[ch_idx] <= rcount_cur + CNTW'(1);
         if (cmd.clr_rec) rcount_ff[ch_idx] <= '0;
         if (cmd.walk_done) rcount_ff[ch_idx] <= w_ff;
         if (cmd.pair_rec) begin
            rcount_ff[ch_idx] <= rcount_cur - CNTW'(1);
            rhead_ff[ch_idx]  <= wrap_add(rhead_cur, CNTW'(1));
         end
         if (cmd.msg_push) mcount_ff[ch_idx] <= meff + CNTW'(1);
         if (cmd.pair_msg) begin
            mcount_ff[ch_idx] <= mcount_cur - CNTW'(1);
            mhead_ff[ch_idx]  <= wrap_add(mhead_cur, CNTW'(1));
         end
      end
   end

   // recipient memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.rec_push) begin
         rec_mem[ch_idx][wrap_add(rhead_cur, rcount_cur)] <= rec_ff;
      end else if (cmd.walk_write && walk_keep) begin
         rec_mem[ch_idx][wrap_add(rhead_cur, w_ff)] <= rec_rdata_ff;
      end
      if (cmd.read_rec_head) begin
         rec_rdata_ff <= rec_mem[ch_idx][rhead_cur];
      end else if (cmd.walk_read) begin
         rec_rdata_ff <= rec_mem[ch_idx][wrap_add(rhead_cur, i_ff)];
      end
   end

   // message memory, name flag on top
   always_ff @(posedge clock) begin
      if (cmd.msg_push) begin
         msg_mem[ch_idx][wrap_add(mhead_cur, meff)] <=
            {!hv_ff, (hv_ff ? val_ff : {VSW{1'b0}})};
      end
      if (cmd.read_msg_head) begin
         msg_rdata_ff <= msg_mem[ch_idx][mhead_cur];
      end
   end

   // remove-all compaction indices
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         w_ff <= '0;
      end else if (cmd.walk_init) begin
         i_ff <= '0;
         w_ff <= '0;
      end else if (cmd.walk_write) begin
         i_ff <= i_ff + CNTW'(1);
         if (walk_keep) w_ff <= w_ff + CNTW'(1);
      end
   end

   // result being built
   always_ff @(posedge clock) begin
      if (cmd.res_none || cmd.res_drop) begin
         res_paired_ff <= 1'b0;
         res_rec_ff    <= '0;
         res_val_ff    <= '0;
         res_name_ff   <= 1'b0;
         res_status_ff <= cmd.res_drop;
      end else if (cmd.pair_msg) begin
         res_paired_ff <= 1'b1;
         res_rec_ff    <= rec_ff;
         res_val_ff    <= msg_rdata_ff[VSW-1:0];
         res_name_ff   <= msg_rdata_ff[VSW];
         res_status_ff <= 1'b0;
      end else if (cmd.pair_rec) begin
         res_paired_ff <= 1'b1;
         res_rec_ff    <= rec_rdata_ff;
         res_val_ff    <= hv_ff ? val_ff : '0;
         res_name_ff   <= !hv_ff;
         res_status_ff <= 1'b0;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_paired_ff <= res_paired_ff;
         out_ch_ff     <= res_paired_ff ? ch_ff : 4'd0;
         out_rec_ff    <= res_rec_ff;
         out_val_ff    <= res_val_ff;
         out_name_ff   <= res_name_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_paired        = out_paired_ff;
   assign rsp_out_channel   = out_ch_ff;
   assign rsp_out_recipient = 8'(out_rec_ff);
   assign rsp_out_value     = 32'(out_val_ff);
   assign rsp_value_is_name = out_name_ff;
   assign rsp_status        = out_status_ff;

   // checks
   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      w_ff <= i_ff) else $error("compaction write index passed read index");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      ch_ok |-> !(rcount_cur != '0 && mcount_cur != '0))
      else $error("both queues of a channel hold entries");
   a_pair_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_paired_ff |-> !out_status_ff)
      else $error("paired word flagged as dropped");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || !rsp_stall))
      else $error("output word overwritten while stalled");

endmodule
